// ----- hw/rtl/grnf_pkg.sv -----
// shared types and constants of the grid rook neighbour finder
package grnf_pkg;

    // fixed field widths
    localparam int IDX_W      = 17;
    localparam int CFG_W      = 9;
    localparam int VAL_W      = 16;
    localparam int NBR_W      = 18;
    localparam int DIR_W      = 2;
    localparam int NUM_DIRS   = 4;
    localparam int PROD_W     = 2 * CFG_W;
    localparam int DIV_STEPS  = IDX_W;

    // stream widths, data padded to whole bytes
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;

    // command queue between front and back, depth must be a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // input function codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // command kinds
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_QERR  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [1:0] REG_COLUMN_COUNT = 2'd1;
    localparam logic [1:0] REG_BACKGROUND   = 2'd2;

    // one classified item; on writes nbr[0] holds the cell address
    typedef struct packed {
        logic [1:0]                      kind;
        logic [VAL_W-1:0]                value;
        logic [NUM_DIRS-1:0]             mask;
        logic [NUM_DIRS-1:0][NBR_W-1:0]  nbr;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] neighbour_index;
        logic [DIR_W-1:0] direction;
        logic             found;
        logic             index_error;
        logic             last;
    } t_result;

endpackage

// ----- hw/rtl/grnf_ram.sv -----
// generic single port ram with registered read
module grnf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/grnf_queue.sv -----
// short command queue between front and back
module grnf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  grnf_pkg::t_cmd  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_head_valid,
    output grnf_pkg::t_cmd  o_head
);

    grnf_pkg::t_cmd                      r_mem [grnf_pkg::QUEUE_DEPTH];
    logic [grnf_pkg::QUEUE_PTR_W-1:0]    r_wr_ptr;
    logic [grnf_pkg::QUEUE_PTR_W-1:0]    r_rd_ptr;
    logic [grnf_pkg::QUEUE_CNT_W-1:0]    r_count;
    logic [grnf_pkg::QUEUE_CNT_W-1:0]    n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_full       = (r_count == grnf_pkg::QUEUE_CNT_W'(grnf_pkg::QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !(i_push && !i_pop))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty queue");
`endif

endmodule

// ----- hw/rtl/grnf_front.sv -----
// front end: accepts items, range checks them, splits query index into row and column
module grnf_front #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic                        i_func,
    input  logic [grnf_pkg::IDX_W-1:0]  i_cell_index,
    input  logic [grnf_pkg::VAL_W-1:0]  i_cell_value,
    input  logic [grnf_pkg::CFG_W-1:0]  i_row_count,
    input  logic [grnf_pkg::CFG_W-1:0]  i_column_count,
    output logic                        o_push,
    output grnf_pkg::t_cmd              o_cmd,
    input  logic                        i_full
);

    localparam logic [2:0] F_IDLE  = 3'd0;
    localparam logic [2:0] F_MUL   = 3'd1;
    localparam logic [2:0] F_CHECK = 3'd2;
    localparam logic [2:0] F_DIV   = 3'd3;
    localparam logic [2:0] F_NBR   = 3'd4;
    localparam logic [2:0] F_PUSH  = 3'd5;

    localparam int CNT_W = $clog2(grnf_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(grnf_pkg::DIV_STEPS - 1);

    logic [2:0]                     r_state;
    logic [2:0]                     n_state;
    logic                           r_func;
    logic [grnf_pkg::IDX_W-1:0]     r_idx;
    logic [grnf_pkg::VAL_W-1:0]     r_value;
    logic [grnf_pkg::CFG_W-1:0]     r_rows;
    logic [grnf_pkg::CFG_W-1:0]     r_cols;
    logic [grnf_pkg::PROD_W-1:0]    r_total;
    logic [grnf_pkg::IDX_W-1:0]     r_p;
    logic [grnf_pkg::IDX_W-1:0]     r_dq;
    logic [grnf_pkg::CFG_W-1:0]     r_rem;
    logic [CNT_W-1:0]               r_cnt;
    grnf_pkg::t_cmd                 r_cmd;

    logic [grnf_pkg::CFG_W-1:0]     rows_eff;
    logic [grnf_pkg::CFG_W-1:0]     cols_eff;
    logic                           in_range;
    logic [grnf_pkg::CFG_W:0]       trial;
    logic                           q_bit;
    logic [grnf_pkg::CFG_W-1:0]     rem_next;
    logic [grnf_pkg::NBR_W-1:0]     p_ext;
    logic [grnf_pkg::NBR_W-1:0]     rows_ext;

    // saturate geometry into 1..max
    always_comb begin
        if (i_row_count == '0) begin
            rows_eff = grnf_pkg::CFG_W'(1);
        end else if (32'(i_row_count) > MAX_ROWS) begin
            rows_eff = grnf_pkg::CFG_W'(MAX_ROWS);
        end else begin
            rows_eff = i_row_count;
        end
        if (i_column_count == '0) begin
            cols_eff = grnf_pkg::CFG_W'(1);
        end else if (32'(i_column_count) > MAX_COLUMNS) begin
            cols_eff = grnf_pkg::CFG_W'(MAX_COLUMNS);
        end else begin
            cols_eff = i_column_count;
        end
    end

    assign in_range = (r_idx != '0) && (grnf_pkg::PROD_W'(r_idx) <= r_total);

    // restoring divide step, one quotient bit per cycle
    assign trial = {r_rem, r_dq[grnf_pkg::IDX_W-1]};
    always_comb begin
        if (trial >= {1'b0, r_rows}) begin
            q_bit    = 1'b1;
            rem_next = grnf_pkg::CFG_W'(trial - {1'b0, r_rows});
        end else begin
            q_bit    = 1'b0;
            rem_next = trial[grnf_pkg::CFG_W-1:0];
        end
    end

    assign p_ext    = grnf_pkg::NBR_W'(r_p);
    assign rows_ext = grnf_pkg::NBR_W'(r_rows);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_CHECK;
            end
            F_CHECK: begin
                if (!in_range) begin
                    n_state = (r_func == grnf_pkg::FUNC_QUERY) ? F_PUSH : F_IDLE;
                end else begin
                    n_state = (r_func == grnf_pkg::FUNC_QUERY) ? F_DIV : F_PUSH;
                end
            end
            F_DIV: begin
                if (r_cnt == LAST_STEP) begin
                    n_state = F_NBR;
                end
            end
            F_NBR: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    r_func  <= i_func;
                    r_idx   <= i_cell_index;
                    r_value <= i_cell_value;
                    r_rows  <= rows_eff;
                    r_cols  <= cols_eff;
                end
            end
            F_MUL: begin
                r_total <= grnf_pkg::PROD_W'(r_rows) * grnf_pkg::PROD_W'(r_cols);
                r_p     <= r_idx - 1'b1;
                r_dq    <= r_idx - 1'b1;
                r_rem   <= '0;
                r_cnt   <= '0;
            end
            F_CHECK: begin
                r_cmd.kind   <= in_range ? grnf_pkg::CMD_WRITE : grnf_pkg::CMD_QERR;
                r_cmd.value  <= r_value;
                r_cmd.mask   <= '0;
                r_cmd.nbr[0] <= p_ext;
            end
            F_DIV: begin
                r_rem <= rem_next;
                r_dq  <= {r_dq[grnf_pkg::IDX_W-2:0], q_bit};
                r_cnt <= r_cnt + 1'b1;
            end
            F_NBR: begin
                // row is the remainder, column the quotient
                r_cmd.kind    <= grnf_pkg::CMD_QUERY;
                r_cmd.mask[0] <= (r_rem != '0);
                r_cmd.mask[1] <= ((grnf_pkg::CFG_W + 1)'(r_rem) + 1'b1) <
                                 (grnf_pkg::CFG_W + 1)'(r_rows);
                r_cmd.mask[2] <= (r_dq != '0);
                r_cmd.mask[3] <= (grnf_pkg::NBR_W'(r_dq) + 1'b1) < grnf_pkg::NBR_W'(r_cols);
                r_cmd.nbr[0]  <= p_ext - 1'b1;
                r_cmd.nbr[1]  <= p_ext + 1'b1;
                r_cmd.nbr[2]  <= p_ext - rows_ext;
                r_cmd.nbr[3]  <= p_ext + rows_ext;
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    assign o_ready = (r_state == F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_full;
    assign o_cmd   = r_cmd;

endmodule

// ----- hw/rtl/grnf_back.sv -----
// back end: owns the grid memory, performs writes and neighbour checks, drives results
module grnf_back #(
    parameter int CELLS      = 65536,
    parameter int VALUE_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_head_valid,
    input  grnf_pkg::t_cmd              i_head,
    output logic                        o_pop,
    input  logic [grnf_pkg::VAL_W-1:0]  i_background,
    output logic                        o_valid,
    input  logic                        i_ready,
    output grnf_pkg::t_result           o_result
);

    localparam int ADDR_W = $clog2(CELLS);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_CMP  = 2'd2;
    localparam logic [1:0] B_EMIT = 2'd3;

    localparam logic [grnf_pkg::DIR_W-1:0] LAST_DIR = grnf_pkg::DIR_W'(grnf_pkg::NUM_DIRS - 1);

    logic [1:0]                         r_state;
    logic [1:0]                         n_state;
    grnf_pkg::t_cmd                     r_cmd;
    logic [grnf_pkg::DIR_W-1:0]         r_k;
    logic [grnf_pkg::NUM_DIRS-1:0]      r_match;
    logic                               r_err;
    logic                               r_out_valid;
    grnf_pkg::t_result                  r_out;

    logic                               ram_we;
    logic [ADDR_W-1:0]                  ram_addr;
    logic [VALUE_BITS-1:0]              ram_wdata;
    logic [VALUE_BITS-1:0]              ram_rdata;
    logic signed [31:0]                 wr_ext;
    logic signed [31:0]                 bg_ext;
    logic [VALUE_BITS-1:0]              bg_cmp;

    logic                               is_write;
    logic                               load;
    logic                               any_match;
    logic [grnf_pkg::DIR_W-1:0]         sel;
    logic [grnf_pkg::NUM_DIRS-1:0]      rest;
    grnf_pkg::t_result                  next_out;

    assign wr_ext    = 32'(signed'(i_head.value));
    assign bg_ext    = 32'(signed'(i_background));
    assign ram_wdata = VALUE_BITS'(wr_ext);
    assign bg_cmp    = VALUE_BITS'(bg_ext);

    assign is_write = (r_state == B_IDLE) && i_head_valid && (i_head.kind == grnf_pkg::CMD_WRITE);
    assign ram_we   = is_write;
    assign ram_addr = (r_state == B_IDLE) ? ADDR_W'(i_head.nbr[0]) : ADDR_W'(r_cmd.nbr[r_k]);
    assign o_pop    = (r_state == B_IDLE) && i_head_valid;

    grnf_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (CELLS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // lowest pending match goes out first
    always_comb begin
        sel = '0;
        for (int k = grnf_pkg::NUM_DIRS - 1; k >= 0; k--) begin
            if (r_match[k]) begin
                sel = grnf_pkg::DIR_W'(k);
            end
        end
    end

    assign any_match = (r_match != '0);
    assign rest      = r_match & ~(grnf_pkg::NUM_DIRS'(1) << sel);
    assign load      = (r_state == B_EMIT) && (!r_out_valid || i_ready);

    always_comb begin
        if (any_match) begin
            next_out.neighbour_index = grnf_pkg::IDX_W'(r_cmd.nbr[sel] + 1'b1);
            next_out.direction       = sel;
            next_out.found           = 1'b1;
            next_out.index_error     = 1'b0;
            next_out.last            = (rest == '0);
        end else begin
            next_out.neighbour_index = '0;
            next_out.direction       = '0;
            next_out.found           = 1'b0;
            next_out.index_error     = r_err;
            next_out.last            = 1'b1;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (i_head_valid) begin
                    if (i_head.kind == grnf_pkg::CMD_QUERY) begin
                        n_state = B_RD;
                    end else if (i_head.kind != grnf_pkg::CMD_WRITE) begin
                        n_state = B_EMIT;
                    end
                end
            end
            B_RD: begin
                n_state = B_CMP;
            end
            B_CMP: begin
                n_state = (r_k == LAST_DIR) ? B_EMIT : B_RD;
            end
            B_EMIT: begin
                if (load && next_out.last) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (i_head_valid) begin
                    r_cmd   <= i_head;
                    r_k     <= '0;
                    r_match <= '0;
                    r_err   <= (i_head.kind != grnf_pkg::CMD_QUERY);
                end
            end
            B_RD: begin
            end
            B_CMP: begin
                r_match[r_k] <= r_cmd.mask[r_k] && (ram_rdata == bg_cmp);
                r_k          <= r_k + 1'b1;
            end
            B_EMIT: begin
                if (load) begin
                    r_out   <= next_out;
                    r_match <= rest;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

`ifndef NO_ASSERTIONS
    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> !r_out.index_error)
        else $error("matching result flagged as index error");

    a_miss_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> r_out.last)
        else $error("empty result not marked last");

    a_match_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_EMIT) |-> ((r_match & ~r_cmd.mask) == '0))
        else $error("match reported for a neighbour outside the grid");
`endif

endmodule

// ----- hw/rtl/grid_rook_neighbour_finder.sv -----
// top level of the grid rook neighbour finder: config registers, front, queue and back
// a write item passes the front and the queue and is written by the back; a query also
// passes the divider, then gives its results one per cycle while the result side is ready
// the front takes one item at a time and holds a query through the 17-step restoring divider
// reset: clears control state and loads 256 rows, 256 columns and background 0; the grid
// memory is not cleared and a cell reads undefined until written
module grid_rook_neighbour_finder #(
    parameter int MAX_ROWS    = 256,
    parameter int MAX_COLUMNS = 256,
    parameter int VALUE_BITS  = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cell_index [16:0], cell_value [32:17], zero pad [39:33]
    input  logic [grnf_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // func [0]
    input  logic [0:0]                           s_axis_tuser,

    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // neighbour_index [16:0], direction [18:17], zero pad [23:19]
    output logic [grnf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // found [0], index_error [1]
    output logic [grnf_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
    output logic                                 m_axis_tlast,

    // configuration writes
    input  logic                                 i_cfg_wr_en,
    input  logic [1:0]                           i_cfg_index,
    input  logic [grnf_pkg::VAL_W-1:0]           i_cfg_wdata
);

    localparam int CELLS = MAX_ROWS * MAX_COLUMNS;

    logic [grnf_pkg::CFG_W-1:0]  r_row_count;
    logic [grnf_pkg::CFG_W-1:0]  r_column_count;
    logic [grnf_pkg::VAL_W-1:0]  r_background;

    logic                        push;
    logic                        full;
    grnf_pkg::t_cmd              push_cmd;
    logic                        pop;
    logic                        head_valid;
    grnf_pkg::t_cmd              head;
    grnf_pkg::t_result           result;

    // config register file, to be written only while the block is idle; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= grnf_pkg::CFG_W'(256);
            r_column_count <= grnf_pkg::CFG_W'(256);
            r_background   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                grnf_pkg::REG_ROW_COUNT: begin
                    r_row_count <= i_cfg_wdata[grnf_pkg::CFG_W-1:0];
                end
                grnf_pkg::REG_COLUMN_COUNT: begin
                    r_column_count <= i_cfg_wdata[grnf_pkg::CFG_W-1:0];
                end
                grnf_pkg::REG_BACKGROUND: begin
                    r_background <= i_cfg_wdata;
                end
                default: begin
                    // unknown register, write dropped
                end
            endcase
        end
    end

    // front: takes one transaction, range checks it and splits the index
    grnf_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_func         (s_axis_tuser[0]),
        .i_cell_index   (s_axis_tdata[grnf_pkg::IDX_W-1:0]),
        .i_cell_value   (s_axis_tdata[grnf_pkg::IDX_W +: grnf_pkg::VAL_W]),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .o_push         (push),
        .o_cmd          (push_cmd),
        .i_full         (full)
    );

    // commands keep their order, so a write is seen by every later query
    grnf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_data       (push_cmd),
        .o_full       (full),
        .i_pop        (pop),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    // back: grid memory, four neighbour reads per query, output register
    grnf_back #(
        .CELLS      (CELLS),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .i_background (r_background),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {
        (grnf_pkg::OUT_TDATA_W - grnf_pkg::IDX_W - grnf_pkg::DIR_W)'(0),
        result.direction,
        result.neighbour_index
    };
    assign m_axis_tuser = {result.index_error, result.found};
    assign m_axis_tlast = result.last;

endmodule

// ----- verif/grid_rook_neighbour_finder_test.sv -----
// self-checking testbench of the grid rook neighbour finder
`timescale 1ns / 1ps

module grid_rook_neighbour_finder_test;

    import grnf_pkg::*;

    // grid size limits of the default build
    localparam int unsigned GRID_ROWS_MAX = 256;
    localparam int unsigned GRID_COLS_MAX = 256;
    localparam int unsigned INDEX_TOP     = 131071;

    // neighbour side codes as they appear on the result stream
    localparam logic [DIR_W-1:0] SIDE_ABOVE = 2'd0;
    localparam logic [DIR_W-1:0] SIDE_BELOW = 2'd1;
    localparam logic [DIR_W-1:0] SIDE_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] SIDE_RIGHT = 2'd3;

    // register index with no register behind it
    localparam logic [1:0] REG_SPARE = 2'd3;

    // cycles to let a write settle in the grid before a register change
    localparam int DRAIN_CYCLES = 40;

    // fixed results of a query that finds nothing or misses the grid
    localparam t_result ERR_RESULT = '{neighbour_index: '0, direction: SIDE_ABOVE,
                                       found: 1'b0, index_error: 1'b1, last: 1'b1};
    localparam t_result NONE_RESULT = '{neighbour_index: '0, direction: SIDE_ABOVE,
                                        found: 1'b0, index_error: 1'b0, last: 1'b1};

    typedef enum logic {ROW_REG, ROW_ITEM} t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind        kind;
        logic [1:0]       reg_idx;
        logic [VAL_W-1:0] reg_data;
        logic             func;
        logic [IDX_W-1:0] cell_idx;
        logic [VAL_W-1:0] value;
        bit               typed;
        t_result          want;
    } t_plan_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // cell_index [16:0], cell_value [32:17], zero pad [39:33]
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // func [0]
    logic [0:0]              s_axis_tuser = '0;

    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // neighbour_index [16:0], direction [18:17], zero pad [23:19]
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // found [0], index_error [1]
    logic [OUT_TUSER_W-1:0]  m_axis_tuser;
    logic                    m_axis_tlast;

    logic                    i_cfg_wr_en = 1'b0;
    logic [1:0]              i_cfg_index = '0;
    logic [VAL_W-1:0]        i_cfg_wdata = '0;

    // mirror of the block: registers as written, grid contents and which cells hold data
    logic [CFG_W-1:0] cfg_rows = 9'd256;
    logic [CFG_W-1:0] cfg_cols = 9'd256;
    logic [VAL_W-1:0] cfg_background = '0;
    logic [VAL_W-1:0] grid_mirror [GRID_ROWS_MAX*GRID_COLS_MAX];
    bit               grid_written [GRID_ROWS_MAX*GRID_COLS_MAX];

    // results still owed by the block, oldest first
    t_result results_due [$];

    int  mismatches = 0;
    int  items_sent = 0;
    int  stall_left = 0;
    bit  steady = 1'b0;

    t_plan_row plan [$];

    always #5 i_clk = ~i_clk;

    grid_rook_neighbour_finder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // appends one result to the owed list
    function automatic void owe_result(input t_result r);
        results_due.insert(results_due.size(), r);
    endfunction

    // register values outside 1..max saturate, zero acts as one
    function automatic int unsigned grid_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > GRID_ROWS_MAX) return GRID_ROWS_MAX;
        return int'(cfg_rows);
    endfunction

    function automatic int unsigned grid_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > GRID_COLS_MAX) return GRID_COLS_MAX;
        return int'(cfg_cols);
    endfunction

    // zero-based addresses of the in-grid rook neighbours of cell p, in scan order
    function automatic int list_neighbours(input int unsigned p, input int unsigned rows,
                                           input int unsigned cols,
                                           output int unsigned addr [4],
                                           output logic [DIR_W-1:0] side [4]);
        int unsigned row;
        int unsigned col;
        int n;
        row = p % rows;
        col = p / rows;
        n = 0;
        addr = '{0, 0, 0, 0};
        side = '{SIDE_ABOVE, SIDE_ABOVE, SIDE_ABOVE, SIDE_ABOVE};
        if (row > 0) begin
            addr[n] = p - 1;
            side[n] = SIDE_ABOVE;
            n++;
        end
        if (row + 1 < rows) begin
            addr[n] = p + 1;
            side[n] = SIDE_BELOW;
            n++;
        end
        if (col > 0) begin
            addr[n] = p - rows;
            side[n] = SIDE_LEFT;
            n++;
        end
        if (col + 1 < cols) begin
            addr[n] = p + rows;
            side[n] = SIDE_RIGHT;
            n++;
        end
        return n;
    endfunction

    // applies one accepted item to the mirror and queues the results it owes
    function automatic void predict_lookup(input logic func, input logic [IDX_W-1:0] cell_idx,
                                           input logic [VAL_W-1:0] value);
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        int unsigned idx;
        int unsigned addr [4];
        logic [DIR_W-1:0] side [4];
        int n;
        bit any;
        t_result r;
        rows = grid_rows();
        cols = grid_cols();
        total = rows * cols;
        idx = int'(cell_idx);
        if (func == FUNC_WRITE) begin
            // out-of-grid writes are dropped silently
            if (idx >= 1 && idx <= total) begin
                grid_mirror[idx-1] = value;
                grid_written[idx-1] = 1'b1;
            end
            return;
        end
        if (idx < 1 || idx > total) begin
            owe_result(ERR_RESULT);
            return;
        end
        n = list_neighbours(idx - 1, rows, cols, addr, side);
        any = 1'b0;
        for (int k = 0; k < n; k++) begin
            if (grid_mirror[addr[k]] == cfg_background) begin
                r = '{neighbour_index: IDX_W'(addr[k] + 1), direction: side[k],
                      found: 1'b1, index_error: 1'b0, last: 1'b0};
                owe_result(r);
                any = 1'b1;
            end
        end
        if (!any)
            owe_result(NONE_RESULT);
        else
            results_due[results_due.size()-1].last = 1'b1;
    endfunction

    // biased toward the free value so that matches are common
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return cfg_background;
            5:             return 16'h8000;
            6:             return 16'h7FFF;
            default:       return VAL_W'($urandom);
        endcase
    endfunction

    // edges and corners come up often even on the large grid
    function automatic int unsigned pick_coord(input int unsigned n);
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return n - 1;
            default: return $urandom_range(0, n - 1);
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_cell(input int unsigned rows,
                                                   input int unsigned cols);
        return IDX_W'(pick_coord(rows) + pick_coord(cols) * rows + 1);
    endfunction

    function automatic logic [IDX_W-1:0] pick_outside(input int unsigned total);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return IDX_W'(total + 1);
            default: return IDX_W'($urandom_range(total + 1, INDEX_TOP));
        endcase
    endfunction

    function automatic t_plan_row reg_row(input logic [1:0] idx, input logic [VAL_W-1:0] data);
        reg_row = '0;
        reg_row.kind = ROW_REG;
        reg_row.reg_idx = idx;
        reg_row.reg_data = data;
    endfunction

    function automatic t_plan_row item_row(input logic func, input int unsigned cell_idx,
                                           input logic [VAL_W-1:0] value);
        item_row = '0;
        item_row.kind = ROW_ITEM;
        item_row.func = func;
        item_row.cell_idx = IDX_W'(cell_idx);
        item_row.value = value;
    endfunction

    function automatic t_plan_row typed_row(input int unsigned cell_idx, input t_result want);
        typed_row = item_row(FUNC_QUERY, cell_idx, 16'hFFFF);
        typed_row.typed = 1'b1;
        typed_row.want = want;
    endfunction

    // one input transaction; valid stays high into the next call unless a gap is drawn
    task automatic push_item(input logic func, input logic [IDX_W-1:0] cell_idx,
                             input logic [VAL_W-1:0] value, input bit typed,
                             input t_result want);
        int unsigned total;
        total = grid_rows() * grid_cols();
        if (!steady && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, value, cell_idx};
        s_axis_tuser <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        // dropped writes are not counted as work
        if (func == FUNC_QUERY || (cell_idx >= 1 && int'(cell_idx) <= total))
            items_sent++;
        if (typed)
            owe_result(want);
        else
            predict_lookup(func, cell_idx, value);
    endtask

    // register writes happen only with the block drained
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [VAL_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        case (idx)
            REG_ROW_COUNT:    cfg_rows = data[CFG_W-1:0];
            REG_COLUMN_COUNT: cfg_cols = data[CFG_W-1:0];
            REG_BACKGROUND:   cfg_background = data;
            default: ;
        endcase
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // one grid setting, then random traffic until the quota of useful items is met
    task automatic run_phase(input logic [VAL_W-1:0] rows_w, input logic [VAL_W-1:0] cols_w,
                             input logic [VAL_W-1:0] bg_w, input int quota, input bit spare);
        int start;
        int unsigned rows;
        int unsigned cols;
        int unsigned total;
        int unsigned addr [4];
        logic [DIR_W-1:0] side [4];
        logic [IDX_W-1:0] cell_idx;
        int n;
        int pick;
        wait_idle();
        write_reg(REG_ROW_COUNT, rows_w);
        write_reg(REG_COLUMN_COUNT, cols_w);
        write_reg(REG_BACKGROUND, bg_w);
        if (spare)
            write_reg(REG_SPARE, VAL_W'($urandom));
        rows = grid_rows();
        cols = grid_cols();
        total = rows * cols;
        start = items_sent;
        while (items_sent - start < quota) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                // well-formed: fill the neighbours that lack data, refresh a few, then query
                cell_idx = pick_cell(rows, cols);
                n = list_neighbours(int'(cell_idx) - 1, rows, cols, addr, side);
                for (int k = 0; k < n; k++) begin
                    if (!grid_written[addr[k]] || $urandom_range(0, 3) == 0)
                        push_item(FUNC_WRITE, IDX_W'(addr[k] + 1), pick_value(), 1'b0, '0);
                end
                push_item(FUNC_QUERY, cell_idx, VAL_W'($urandom), 1'b0, '0);
            end else if (pick < 80) begin
                push_item(FUNC_WRITE, pick_cell(rows, cols), pick_value(), 1'b0, '0);
            end else if (pick < 92) begin
                push_item(FUNC_QUERY, pick_outside(total), VAL_W'($urandom), 1'b0, '0);
            end else begin
                push_item(FUNC_WRITE, pick_outside(total), VAL_W'($urandom), 1'b0, '0);
            end
        end
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t %s: want idx %0d dir %0d found %0d err %0d last %0d, ",
                     $realtime, what, want.neighbour_index, want.direction, want.found,
                     want.index_error, want.last,
                     "got idx %0d dir %0d found %0d err %0d last %0d",
                     got.neighbour_index, got.direction,
                     got.found, got.index_error, got.last);
    endtask

    // result side backpressure: random stall bursts, none in the closing phase
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 8);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // every result transaction is checked against the oldest one owed
    always @(posedge i_clk) begin : check_results
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{neighbour_index: m_axis_tdata[IDX_W-1:0],
                    direction: m_axis_tdata[IDX_W+DIR_W-1:IDX_W],
                    found: m_axis_tuser[0], index_error: m_axis_tuser[1],
                    last: m_axis_tlast};
            if (results_due.size() == 0) begin
                note_mismatch("result with none owed", '0, got);
            end else begin
                want = results_due.pop_front();
                if (got.neighbour_index !== want.neighbour_index ||
                    got.direction !== want.direction || got.found !== want.found ||
                    got.index_error !== want.index_error || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    initial begin
        // directed part: errors at the index extremes, the far corner of the full grid,
        // then a filled 3x3 grid, then a register-saturated single-row grid
        plan = '{
            typed_row(0, ERR_RESULT),
            typed_row(65537, ERR_RESULT),
            typed_row(INDEX_TOP, ERR_RESULT),
            item_row(FUNC_WRITE, 0, 16'd1234),
            item_row(FUNC_WRITE, INDEX_TOP, 16'h7FFF),
            item_row(FUNC_WRITE, 65535, 16'h7FFF),
            item_row(FUNC_WRITE, 65280, 16'h0000),
            item_row(FUNC_WRITE, 65536, 16'h8000),
            item_row(FUNC_QUERY, 65536, 16'hFFFF),
            reg_row(REG_ROW_COUNT, 16'd3),
            reg_row(REG_COLUMN_COUNT, 16'd3),
            reg_row(REG_BACKGROUND, 16'h8000),
            item_row(FUNC_WRITE, 1, 16'h8000),
            item_row(FUNC_WRITE, 2, 16'h0007),
            item_row(FUNC_WRITE, 3, 16'h8000),
            item_row(FUNC_WRITE, 4, 16'h0009),
            item_row(FUNC_WRITE, 5, 16'h8000),
            item_row(FUNC_WRITE, 6, 16'h8000),
            item_row(FUNC_WRITE, 7, 16'hFFFF),
            item_row(FUNC_WRITE, 8, 16'h8000),
            item_row(FUNC_WRITE, 9, 16'h7FFF),
            typed_row(1, NONE_RESULT),
            item_row(FUNC_QUERY, 5, 16'h0000),
            item_row(FUNC_QUERY, 9, 16'h5A5A),
            item_row(FUNC_QUERY, 3, 16'h8000),
            typed_row(10, ERR_RESULT),
            // zero rows acts as one, 511 columns saturates to the maximum
            reg_row(REG_ROW_COUNT, 16'h0200),
            reg_row(REG_COLUMN_COUNT, 16'h01FF),
            reg_row(REG_SPARE, 16'hFFFF),
            item_row(FUNC_QUERY, 1, 16'h7FFF),
            typed_row(257, ERR_RESULT)
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                if (i == 0 || plan[i-1].kind == ROW_ITEM)
                    wait_idle();
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                push_item(plan[i].func, plan[i].cell_idx, plan[i].value, plan[i].typed,
                          plan[i].want);
            end
        end

        // random part over a spread of grid shapes, the register extremes among them
        run_phase(16'd256, 16'd256, VAL_W'($urandom), 70, 1'b0);
        run_phase(16'd1, 16'd1, 16'h7FFF, 25, 1'b1);
        run_phase(16'd1, 16'd256, 16'h8000, 50, 1'b0);
        run_phase(16'd256, 16'hFE00, VAL_W'($urandom), 50, 1'b0);
        run_phase(16'd2, 16'd2, 16'h0000, 40, 1'b1);
        run_phase({7'($urandom), 9'($urandom_range(1, 16))},
                  {7'($urandom), 9'($urandom_range(1, 16))}, VAL_W'($urandom), 60, 1'b0);
        run_phase({7'($urandom), 9'($urandom_range(257, 511))},
                  VAL_W'($urandom_range(1, 40)), VAL_W'($urandom), 60, 1'b1);
        // closing phase runs with both sides at full rate
        steady = 1'b1;
        run_phase(16'd256, 16'd256, 16'h8000, 60, 1'b0);

        s_axis_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #5000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
